// File: hdl/lpc_pkg.sv
`timescale 1ns / 1ps
package lpc_pkg;

	// Point index and finite-point counter width; the counter saturates at its top value.
	localparam int INDEX_BITS = 16;
	localparam logic [INDEX_BITS-1:0] COUNT_MAX = '1;

	// Width of the reported curvature; larger sums clamp to all ones.
	localparam int CURV_BITS = 57;

	// Side information that travels down the pipeline next to the arithmetic.
	typedef struct packed {
		logic                  has_value;
		logic                  last;
		logic [INDEX_BITS-1:0] index;
	} ctrl_t;

	// Load enables handed from the top level to each axis datapath.
	typedef struct packed {
		logic shift;
		logic ld_s2;
		logic ld_s3;
		logic ld_s4;
	} stage_en_t;

endpackage

// File: hdl/lpc_axis.sv
`timescale 1ns / 1ps
module lpc_axis #(
	parameter int HALF_WINDOW = 5,
	parameter int COORD_BITS  = 24
) (
	input  logic                                                      clk,
	input  lpc_pkg::stage_en_t                                        en,
	input  logic signed [COORD_BITS-1:0]                              coord,
	output logic [2*(COORD_BITS+$clog2(2*HALF_WINDOW))-1:0]           square_s4
);
	import lpc_pkg::*;

	localparam int WIN_LEN  = 2 * HALF_WINDOW + 1;
	localparam int MAG_BITS = COORD_BITS + $clog2(2 * HALF_WINDOW);
	localparam int SQ_BITS  = 2 * MAG_BITS;
	localparam logic signed [MAG_BITS-1:0] SCALE = MAG_BITS'(2 * HALF_WINDOW);

	logic signed [COORD_BITS-1:0] win_q [WIN_LEN];
	logic signed [MAG_BITS-1:0]   nsum;
	logic signed [MAG_BITS-1:0]   nsum_s2;
	logic signed [MAG_BITS-1:0]   cscl_s2;
	logic signed [MAG_BITS:0]     diff;
	logic        [MAG_BITS-1:0]   mag;
	logic        [MAG_BITS-1:0]   mag_s3;

	// Shift line of the most recent finite points; the centre sits in the middle tap.
	always_ff @(posedge clk) begin
		if (en.shift) begin
			for (int i = 0; i < WIN_LEN - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[WIN_LEN-1] <= coord;
		end
	end

	always_comb begin
		nsum = '0;
		for (int i = 0; i < WIN_LEN; i++) begin
			if (i != HALF_WINDOW) begin
				nsum = nsum + MAG_BITS'(win_q[i]);
			end
		end
	end

	assign diff = (MAG_BITS+1)'(nsum_s2) - (MAG_BITS+1)'(cscl_s2);
	assign mag  = diff[MAG_BITS] ? MAG_BITS'(-diff) : MAG_BITS'(diff);

	always_ff @(posedge clk) begin
		if (en.ld_s2) begin
			nsum_s2 <= nsum;
			cscl_s2 <= MAG_BITS'(win_q[HALF_WINDOW]) * SCALE;
		end
		if (en.ld_s3) begin
			mag_s3 <= mag;
		end
		if (en.ld_s4) begin
			square_s4 <= SQ_BITS'(mag_s3) * SQ_BITS'(mag_s3);
		end
	end

endmodule

// File: hdl/lidar_point_curvature_unit.sv
`timescale 1ns / 1ps
// Five-stage pipeline with two multipliers per axis: a request passes through the window,
// neighbor sum, magnitude, square, and sum and clamp registers before its result is output.
// Throughput: one request per cycle, unless back-pressure from out_ready stalls it.
// Reset: arst_n clears the point counter and all stage valids; window data is not reset.
module lidar_point_curvature_unit #(
	parameter int HALF_WINDOW = 5,
	parameter int COORD_BITS  = 24
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [COORD_BITS-1:0]     x_coord,
	input  logic signed [COORD_BITS-1:0]     y_coord,
	input  logic signed [COORD_BITS-1:0]     z_coord,
	input  logic                             point_finite,
	input  logic                             scan_end,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [lpc_pkg::CURV_BITS-1:0]    curvature,
	output logic [lpc_pkg::INDEX_BITS-1:0]   point_index,
	output logic                             has_value,
	output logic                             last_of_scan
);
	import lpc_pkg::*;

	localparam int MAG_BITS = COORD_BITS + $clog2(2 * HALF_WINDOW);
	localparam int SQ_BITS  = 2 * MAG_BITS;
	localparam int SUM_BITS = SQ_BITS + 2;
	// A point completes a window once it is at least this far into the scan.
	localparam logic [INDEX_BITS-1:0] CENTRE_MIN = INDEX_BITS'(2 * HALF_WINDOW);
	localparam logic [INDEX_BITS-1:0] CENTRE_OFS = INDEX_BITS'(HALF_WINDOW);

	// Dense index of the next finite point within the current scan.
	logic [INDEX_BITS-1:0] cnt_q;

	// Stage valids and the control word that rides along with each stage.
	logic  vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	ctrl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5;
	logic  rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;

	logic      in_acc;
	logic      val_in;
	stage_en_t en;

	logic [SQ_BITS-1:0]   sq_x, sq_y, sq_z;
	logic [SUM_BITS-1:0]  sum;
	logic                 ovf;
	logic [CURV_BITS-1:0] curv_clamped;
	logic [CURV_BITS-1:0] curvature_s5;

	// Each stage can take new data when it is empty or its content moves on
	// this cycle, so bubbles collapse; the ready chain is combinational from
	// out_ready back to in_ready, so the two sides of the block are not decoupled.
	assign rdy_s5 = !vld_s5 || out_ready;
	assign rdy_s4 = !vld_s4 || rdy_s5;
	assign rdy_s3 = !vld_s3 || rdy_s4;
	assign rdy_s2 = !vld_s2 || rdy_s3;
	assign rdy_s1 = !vld_s1 || rdy_s2;

	assign in_ready = rdy_s1;
	assign in_acc   = in_valid && in_ready;

	// A finite point yields a curvature once the window behind it is full.
	assign val_in = point_finite && (cnt_q >= CENTRE_MIN);

	// The window shifts only on finite points; stage 2 samples the window in the
	// same edge that a new point may overwrite it, so it always sees its own point.
	assign en.shift = in_acc && point_finite;
	assign en.ld_s2 = rdy_s2 && vld_s1;
	assign en.ld_s3 = rdy_s3 && vld_s2;
	assign en.ld_s4 = rdy_s4 && vld_s3;

	lpc_axis #(.HALF_WINDOW(HALF_WINDOW), .COORD_BITS(COORD_BITS)) u_axis_x (
		.clk       (clk),
		.en        (en),
		.coord     (x_coord),
		.square_s4 (sq_x)
	);

	lpc_axis #(.HALF_WINDOW(HALF_WINDOW), .COORD_BITS(COORD_BITS)) u_axis_y (
		.clk       (clk),
		.en        (en),
		.coord     (y_coord),
		.square_s4 (sq_y)
	);

	lpc_axis #(.HALF_WINDOW(HALF_WINDOW), .COORD_BITS(COORD_BITS)) u_axis_z (
		.clk       (clk),
		.en        (en),
		.coord     (z_coord),
		.square_s4 (sq_z)
	);

	// Sum of the three squares, clamped to the width of the curvature port.
	// With the default sizes the clamp never engages.
	assign sum = SUM_BITS'(sq_x) + SUM_BITS'(sq_y) + SUM_BITS'(sq_z);
	assign ovf = (sum >> CURV_BITS) != '0;
	assign curv_clamped = ovf ? '1 : CURV_BITS'(sum);

	// Point counter: counts finite points, saturates at the top value and
	// starts over after the request that ends a scan.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (in_acc) begin
			if (scan_end) begin
				cnt_q <= '0;
			end else if (point_finite && cnt_q != COUNT_MAX) begin
				cnt_q <= cnt_q + INDEX_BITS'(1);
			end
		end
	end

	// Stage valids. Only requests that produce a result enter stage 1: a
	// curvature value, an end-of-scan marker, or both.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				vld_s1 <= in_acc && (val_in || scan_end);
			end
			if (rdy_s2) begin
				vld_s2 <= vld_s1;
			end
			if (rdy_s3) begin
				vld_s3 <= vld_s2;
			end
			if (rdy_s4) begin
				vld_s4 <= vld_s3;
			end
			if (rdy_s5) begin
				vld_s5 <= vld_s4;
			end
		end
	end

	// Control words and the output payload. An end-only result carries zero
	// in both curvature and index.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			ctl_s1.has_value <= val_in;
			ctl_s1.last      <= scan_end;
			ctl_s1.index     <= val_in ? (cnt_q - CENTRE_OFS) : '0;
		end
		if (en.ld_s2) begin
			ctl_s2 <= ctl_s1;
		end
		if (en.ld_s3) begin
			ctl_s3 <= ctl_s2;
		end
		if (en.ld_s4) begin
			ctl_s4 <= ctl_s3;
		end
		if (rdy_s5 && vld_s4) begin
			ctl_s5       <= ctl_s4;
			curvature_s5 <= ctl_s4.has_value ? curv_clamped : '0;
		end
	end

	assign out_valid    = vld_s5;
	assign curvature    = curvature_s5;
	assign point_index  = ctl_s5.index;
	assign has_value    = ctl_s5.has_value;
	assign last_of_scan = ctl_s5.last;

`ifndef ASSERT_OFF
	// An end-only result must not leak stale arithmetic.
	a_end_only_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !has_value) |-> (curvature == '0 && point_index == '0))
		else $error("end-only result carries nonzero curvature or index");

	// A reported centre always has a full half window before it.
	a_index_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && has_value) |-> (point_index >= CENTRE_OFS))
		else $error("centre index below half window");

	// The counter restarts after the request that closes a scan.
	a_scan_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && scan_end) |=> (cnt_q == '0))
		else $error("point counter not cleared at scan end");

	// A finite point inside a scan, below the top count, advances the counter by exactly one.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !scan_end && point_finite && cnt_q != COUNT_MAX)
		|=> (cnt_q == $past(cnt_q) + INDEX_BITS'(1)))
		else $error("point counter did not advance");

	// Backpressure on the input only arises when stage 1 holds a request.
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> vld_s1)
		else $error("input stalled with stage 1 empty");
`endif

endmodule

// File: verif/tb_lidar_point_curvature_unit.sv
`timescale 1ns / 1ps
module tb_lidar_point_curvature_unit;
	import lpc_pkg::*;

	// Window geometry and coordinate width of the default build.
	localparam int HALF = 5;
	localparam int SPAN = 2 * HALF + 1;
	localparam int COORD_W = 24;
	localparam logic [63:0] CURV_TOP = (64'd1 << CURV_BITS) - 64'd1;
	localparam logic [COORD_W-1:0] C_MAX = 24'h7FFFFF;
	localparam logic [COORD_W-1:0] C_MIN = 24'h800000;

	localparam int DIR_ROWS = 24;
	localparam int RAND_PER_PHASE = 440;
	// Idle clocks after the final drain, when the block is already empty.
	localparam int TAIL_CYCLES = 16;
	// Watchdog bound; a full run stays well below it even with both sides stalling.
	localparam int CYCLE_LIMIT = 50000;
	localparam int MAX_REPORTS = 20;

	// One result as it leaves the block.
	typedef struct packed {
		logic [CURV_BITS-1:0]  curv;
		logic [INDEX_BITS-1:0] idx;
		logic                  has_value;
		logic                  last;
	} curv_result_t;

	// One point request, with an optional hand-typed expectation for directed rows.
	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
		logic               finite;
		logic               last;
		logic               typed;
		curv_result_t       want;
	} point_req_t;

	localparam curv_result_t NO_RESULT = '0;
	localparam curv_result_t END_ONLY = '{curv: '0, idx: '0, has_value: 1'b0, last: 1'b1};

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic [COORD_W-1:0]     x_coord = '0;
	logic [COORD_W-1:0]     y_coord = '0;
	logic [COORD_W-1:0]     z_coord = '0;
	logic                   point_finite = 1'b0;
	logic                   scan_end = 1'b0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [CURV_BITS-1:0]   curvature;
	logic [INDEX_BITS-1:0]  point_index;
	logic                   has_value;
	logic                   last_of_scan;

	// Hand-typed expectation that travels with the request currently on the bus.
	logic                   cur_typed = 1'b0;
	curv_result_t           cur_want = '0;

	// Idle percentages of the sender and the receiver for the current phase.
	int                     send_idle = 0;
	int                     recv_idle = 0;

	// Predictor state: a shadow of the three coordinate windows and the finite-point count.
	longint                 shadow_win [3][SPAN];
	int unsigned            scan_count = 0;

	curv_result_t           pending_results [$];
	int                     err_count = 0;
	int                     cycles = 0;
	point_req_t             dir_table [DIR_ROWS];

	lidar_point_curvature_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.x_coord      (x_coord),
		.y_coord      (y_coord),
		.z_coord      (z_coord),
		.point_finite (point_finite),
		.scan_end     (scan_end),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.curvature    (curvature),
		.point_index  (point_index),
		.has_value    (has_value),
		.last_of_scan (last_of_scan)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Squared difference on one axis: the ten neighbors minus ten times the center.
	function automatic logic [63:0] axis_energy(input int a);
		longint total;
		total = 0;
		for (int i = 0; i < SPAN; i++)
			total += shadow_win[a][i];
		total -= SPAN * shadow_win[a][HALF];
		if (total < 0)
			total = -total;
		return 64'(total * total);
	endfunction

	// Advances the shadow state by one request and tells whether a result is due.
	function automatic bit predict_curvature(input point_req_t r, output curv_result_t res);
		logic [COORD_W-1:0] coord [3];
		logic [63:0]        energy;
		int unsigned        idx;
		bit                 due;
		coord[0] = r.x;
		coord[1] = r.y;
		coord[2] = r.z;
		energy = '0;
		due = 1'b0;
		idx = scan_count;
		if (r.finite) begin
			for (int a = 0; a < 3; a++) begin
				for (int i = 0; i < SPAN - 1; i++)
					shadow_win[a][i] = shadow_win[a][i + 1];
				shadow_win[a][SPAN - 1] = longint'($signed(coord[a]));
			end
			// The counter sticks at its top value, so later points share that index.
			if (scan_count < COUNT_MAX)
				scan_count++;
			// The window is only read once it holds a full set of points of this scan.
			if (idx >= 2 * HALF) begin
				for (int a = 0; a < 3; a++)
					energy += axis_energy(a);
				if (energy > CURV_TOP)
					energy = CURV_TOP;
				due = 1'b1;
			end
		end
		if (r.last)
			scan_count = 0;
		res.curv = energy[CURV_BITS-1:0];
		res.idx = due ? INDEX_BITS'(idx - HALF) : '0;
		res.has_value = due;
		res.last = r.last;
		return due || r.last;
	endfunction

	// Random coordinate: full range half the time, extremes or small values a quarter of the time each.
	function automatic logic [COORD_W-1:0] rand_coord();
		case ($urandom_range(3))
			0: return $urandom_range(1) ? C_MAX : C_MIN;
			1: return COORD_W'($urandom_range(4095)) - 24'd2048;
			default: return COORD_W'($urandom());
		endcase
	endfunction

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want != got) begin
			err_count++;
			if (err_count <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	// Presents one request, after a random idle gap, and returns at the edge that accepts it.
	task automatic send_point(input point_req_t r);
		if ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		x_coord <= r.x;
		y_coord <= r.y;
		z_coord <= r.z;
		point_finite <= r.finite;
		scan_end <= r.last;
		cur_typed <= r.typed;
		cur_want <= r.want;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Holds the sender off until every outstanding result has come back.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// One scan: mostly long enough to give results, sometimes short, with skipped points
	// sprinkled in; one scan in ten skips about half of its points.
	task automatic random_scan(inout int counted);
		point_req_t r;
		int         n;
		int         skip_pct;
		n = ($urandom_range(99) < 75) ? $urandom_range(40, 12) : $urandom_range(11, 0);
		skip_pct = ($urandom_range(9) == 0) ? 50 : 8;
		for (int i = 0; i <= n; i++) begin
			r = '0;
			r.x = rand_coord();
			r.y = rand_coord();
			r.z = rand_coord();
			r.finite = ($urandom_range(99) >= skip_pct);
			r.last = (i == n);
			send_point(r);
			counted++;
		end
	endtask

	task automatic run_phase(input int sender_pct, input int receiver_pct);
		int counted;
		counted = 0;
		send_idle = sender_pct;
		recv_idle = receiver_pct;
		while (counted < RAND_PER_PHASE)
			random_scan(counted);
	endtask

	// The receiver stalls at random, one decision per clock.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle);
	end

	// Scoreboard: results are checked against the oldest expectation, and every accepted
	// request runs through the predictor. A result can never belong to a request that is
	// accepted at the same edge, so the order of the two halves does not matter.
	always @(posedge clk) begin : scoreboard
		curv_result_t got;
		curv_result_t want;
		curv_result_t pred;
		point_req_t   req;
		bit           due;
		if (arst_n && out_valid && out_ready) begin
			got.curv = curvature;
			got.idx = point_index;
			got.has_value = has_value;
			got.last = last_of_scan;
			if (pending_results.size() == 0) begin
				err_count++;
				if (err_count <= MAX_REPORTS)
					$display("%0t: unexpected result, expected none, actual %0d %0d %0b %0b",
						$time, got.curv, got.idx, got.has_value, got.last);
			end else begin
				want = pending_results.pop_front();
				check_field("curvature", 64'(want.curv), 64'(got.curv));
				check_field("point_index", 64'(want.idx), 64'(got.idx));
				check_field("has_value", 64'(want.has_value), 64'(got.has_value));
				check_field("last_of_scan", 64'(want.last), 64'(got.last));
			end
		end
		if (arst_n && in_valid && in_ready) begin
			req = '0;
			req.x = x_coord;
			req.y = y_coord;
			req.z = z_coord;
			req.finite = point_finite;
			req.last = scan_end;
			due = predict_curvature(req, pred);
			// A directed row with a typed expectation takes precedence over the predictor,
			// which still runs so that its state follows the block.
			if (cur_typed)
				pending_results.push_back(cur_want);
			else if (due)
				pending_results.push_back(pred);
		end
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;

		// Directed rows. An empty scan gives an end-only result. The second scan has five
		// points at the top, a skipped point, a center at the bottom and five more at the top:
		// each axis differs by 10 * (2^24 - 1), so the curvature is 3 * 100 * (2^24 - 1)^2 for
		// center 5, and the same request ends the scan. The third scan stays one point short
		// of a full window and ends on a skipped point, which again gives an end-only result.
		dir_table = '{
			'{24'h000000, 24'h000000, 24'h000000, 1'b0, 1'b1, 1'b1, END_ONLY},
			'{C_MAX, C_MAX, C_MAX, 1'b1, 1'b0, 1'b0, NO_RESULT},
			'{C_MAX, C_MAX, C_MAX, 1'b1, 1'b0, 1'b0, NO_RESULT},
			'{C_MAX, C_MAX, C_MAX, 1'b1, 1'b0, 1'b0, NO_RESULT},
			'{C_MAX, C_MAX, C_MAX, 1'b1, 1'b0, 1'b0, NO_RESULT},
			'{C_MAX, C_MAX, C_MAX, 1'b1, 1'b0, 1'b0, NO_RESULT},
			'{24'h000000, 24'h000000, 24'h000000, 1'b0, 1'b0, 1'b0, NO_RESULT},
			'{C_MIN, C_MIN, C_MIN, 1'b1, 1'b0, 1'b0, NO_RESULT},
			'{C_MAX, C_MAX, C_MAX, 1'b1, 1'b0, 1'b0, NO_RESULT},
			'{C_MAX, C_MAX, C_MAX, 1'b1, 1'b0, 1'b0, NO_RESULT},
			'{C_MAX, C_MAX, C_MAX, 1'b1, 1'b0, 1'b0, NO_RESULT},
			'{C_MAX, C_MAX, C_MAX, 1'b1, 1'b0, 1'b0, NO_RESULT},
			'{C_MAX, C_MAX, C_MAX, 1'b1, 1'b1, 1'b1,
				'{57'd84442482946867500, 16'd5, 1'b1, 1'b1}},
			'{24'h000001, 24'hFFFFFF, 24'h000000, 1'b1, 1'b0, 1'b0, NO_RESULT},
			'{C_MIN, C_MAX, 24'h123456, 1'b1, 1'b0, 1'b0, NO_RESULT},
			'{24'hAAAAAA, 24'h555555, 24'hFEDCBA, 1'b1, 1'b0, 1'b0, NO_RESULT},
			'{24'h000000, 24'h000000, 24'h000000, 1'b1, 1'b0, 1'b0, NO_RESULT},
			'{C_MAX, C_MIN, C_MAX, 1'b1, 1'b0, 1'b0, NO_RESULT},
			'{24'h7FF000, 24'h800FFF, 24'h000400, 1'b1, 1'b0, 1'b0, NO_RESULT},
			'{24'hFFFC00, 24'h000400, 24'hFFFFFF, 1'b1, 1'b0, 1'b0, NO_RESULT},
			'{24'h0F0F0F, 24'hF0F0F0, 24'h00FF00, 1'b1, 1'b0, 1'b0, NO_RESULT},
			'{24'h3C3C3C, 24'hC3C3C3, 24'h000001, 1'b1, 1'b0, 1'b0, NO_RESULT},
			'{C_MIN, C_MIN, C_MIN, 1'b1, 1'b0, 1'b0, NO_RESULT},
			'{C_MAX, C_MAX, C_MAX, 1'b0, 1'b1, 1'b1, END_ONLY}
		};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		send_idle = 23;
		recv_idle = 51;
		foreach (dir_table[i])
			send_point(dir_table[i]);

		// Random scans under three idling patterns, with the sender held off until the
		// block has emptied between the phases.
		run_phase(23, 51);
		drain();
		run_phase(51, 23);
		drain();
		run_phase(0, 0);

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// File: filelist.f
hdl/lpc_pkg.sv
hdl/lpc_axis.sv
hdl/lidar_point_curvature_unit.sv
verif/tb_lidar_point_curvature_unit.sv
